// File: hdl/rasm_pkg.sv
// Package for the rational add/subtract/multiply/reduce unit.
// Holds the field widths, operation codes and sequencer state type.
// No dependencies; every other file of the block imports it.
package rasm_pkg;

	// Width of the signed input numerators; denominators are one bit narrower.
	localparam int WIDTH = 16;
	localparam int DEN_W = WIDTH - 1;
	localparam int PROD_W = 2 * WIDTH;
	localparam int MAG_W = PROD_W;
	localparam int K_W = $clog2(MAG_W);
	localparam int CNT_W = $clog2(MAG_W);
	localparam int RES_NUM_W = 32;
	localparam int RES_DEN_W = 30;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_C,
		ST_COMBINE,
		ST_GCD_TWO,
		ST_GCD_LOOP,
		ST_NUM_GO,
		ST_NUM_WAIT,
		ST_DEN_GO,
		ST_DEN_WAIT,
		ST_DONE
	} state_t;

endpackage

// File: hdl/rasm_in_if.sv
// Request channel of the rational unit: operation and two fractions.
// Depends on rasm_pkg for the field widths.
interface rasm_in_if import rasm_pkg::*; ;
	logic valid;
	logic ready;
	logic [1:0] op;
	logic signed [WIDTH-1:0] lhs_num;
	logic [DEN_W-1:0] lhs_den;
	logic signed [WIDTH-1:0] rhs_num;
	logic [DEN_W-1:0] rhs_den;

	modport source (output valid, op, lhs_num, lhs_den, rhs_num, rhs_den, input ready);
	modport sink (input valid, op, lhs_num, lhs_den, rhs_num, rhs_den, output ready);
endinterface

// File: hdl/rasm_out_if.sv
// Result channel of the rational unit: reduced fraction and error flag.
// Depends on rasm_pkg for the field widths.
interface rasm_out_if import rasm_pkg::*; ;
	logic valid;
	logic ready;
	logic signed [RES_NUM_W-1:0] res_num;
	logic [RES_DEN_W-1:0] res_den;
	logic div_zero;

	modport source (output valid, res_num, res_den, div_zero, input ready);
	modport sink (input valid, res_num, res_den, div_zero, output ready);
endinterface

// File: hdl/rasm_divider.sv
// Restoring divider, one quotient bit per cycle, for the final reduction.
// Depends on rasm_pkg for MAG_W and CNT_W.
module rasm_divider import rasm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAG_W-1:0] dividend,
	input  logic [MAG_W-1:0] divisor,
	output logic             done,
	output logic [MAG_W-1:0] quotient
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0] rem_q;
	logic [MAG_W-1:0] quo_q;
	logic [MAG_W-1:0] dsr_q;
	logic [MAG_W:0]   trial;
	logic [MAG_W+1:0] diff;
	logic             fits;

	assign trial = {rem_q, quo_q[MAG_W-1]};
	assign diff = {1'b0, trial} - {2'b00, dsr_q};
	assign fits = !diff[MAG_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MAG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// The partial remainder stays below the divisor, so it fits MAG_W bits.
			rem_q <= fits ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// File: hdl/rational_add_sub_mul_reduce_unit.sv
// Top level of the rational add/subtract/multiply unit with gcd reduction.
// Depends on rasm_pkg, rasm_in_if, rasm_out_if and rasm_divider.
//
// One request is taken at a time and gives one result; ready is high only while the unit
// is idle. A request with a zero denominator goes straight to the result state and answers 0/1 with div_zero set.
// Otherwise the three cross products go through one shared WIDTH by WIDTH multiplier; a zero
// sum answers 0/1, else a binary gcd on 2*WIDTH-bit magnitudes runs one compare/subtract or
// shift per cycle, and the numerator and denominator are divided by the gcd in a bit-serial
// divider, one after the other.
module rational_add_sub_mul_reduce_unit import rasm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	rasm_in_if.sink    operands,
	rasm_out_if.source result
);

	state_t state_q, state_d;

	logic [1:0]              op_q;
	logic signed [WIDTH-1:0] ln_q;
	logic [DEN_W-1:0]        ld_q;
	logic signed [WIDTH-1:0] rn_q;
	logic [DEN_W-1:0]        rd_q;

	logic signed [WIDTH-1:0]  mul_a;
	logic signed [WIDTH-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] acc_q;
	logic [MAG_W-1:0]         den_q;
	logic [MAG_W-1:0]         mag_q;
	logic                     neg_q;

	logic signed [PROD_W:0] sum;
	logic [PROD_W:0]        sum_abs;
	logic                   is_mul;

	logic [MAG_W-1:0] ga_q;
	logic [MAG_W-1:0] gb_q;
	logic [K_W-1:0]   k_q;
	logic [MAG_W:0]   gdiff;
	logic [MAG_W-1:0] gcd;

	logic             div_start;
	logic [MAG_W-1:0] div_dividend;
	logic             div_done;
	logic [MAG_W-1:0] div_quotient;

	logic signed [MAG_W:0] signed_num;

	logic signed [RES_NUM_W-1:0] res_num_q;
	logic [RES_DEN_W-1:0]        res_den_q;
	logic                        div_zero_q;

	assign is_mul = !(op_q == OP_ADD || op_q == OP_SUB);

	always_comb begin
		case (op_q)
			OP_ADD: sum = {acc_q[PROD_W-1], acc_q} + {prod_s1[PROD_W-1], prod_s1};
			OP_SUB: sum = {acc_q[PROD_W-1], acc_q} - {prod_s1[PROD_W-1], prod_s1};
			default: sum = {acc_q[PROD_W-1], acc_q};
		endcase
		sum_abs = sum[PROD_W] ? (PROD_W+1)'(-sum) : sum;
	end

	assign gdiff = {1'b0, ga_q} - {1'b0, gb_q};
	assign gcd = MAG_W'(gb_q << k_q);
	assign signed_num = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

	rasm_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (gcd),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		operands.ready = (state_q == ST_IDLE);
		result.valid = (state_q == ST_DONE);
		div_start = 1'b0;
		div_dividend = mag_q;
		mul_a = ln_q;
		mul_b = is_mul ? rn_q : $signed({1'b0, rd_q});
		case (state_q)
			ST_IDLE: begin
				if (operands.valid) begin
					if (operands.lhs_den == '0 || operands.rhs_den == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_MUL_A;
					end
				end
			end
			ST_MUL_A: begin
				state_d = ST_MUL_B;
			end
			ST_MUL_B: begin
				mul_a = $signed({1'b0, ld_q});
				mul_b = $signed({1'b0, rd_q});
				state_d = ST_MUL_C;
			end
			ST_MUL_C: begin
				mul_a = $signed({1'b0, ld_q});
				mul_b = rn_q;
				state_d = ST_COMBINE;
			end
			ST_COMBINE: begin
				state_d = (sum == '0) ? ST_DONE : ST_GCD_TWO;
			end
			ST_GCD_TWO: begin
				if (ga_q[0] || gb_q[0]) begin
					state_d = ST_GCD_LOOP;
				end
			end
			ST_GCD_LOOP: begin
				if (ga_q == '0) begin
					state_d = ST_NUM_GO;
				end
			end
			ST_NUM_GO: begin
				div_start = 1'b1;
				state_d = ST_NUM_WAIT;
			end
			ST_NUM_WAIT: begin
				if (div_done) begin
					state_d = ST_DEN_GO;
				end
			end
			ST_DEN_GO: begin
				div_start = 1'b1;
				div_dividend = den_q;
				state_d = ST_DEN_WAIT;
			end
			ST_DEN_WAIT: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (result.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q <= operands.op;
				ln_q <= operands.lhs_num;
				ld_q <= operands.lhs_den;
				rn_q <= operands.rhs_num;
				rd_q <= operands.rhs_den;
				res_num_q <= '0;
				res_den_q <= RES_DEN_W'(1);
				div_zero_q <= (operands.lhs_den == '0 || operands.rhs_den == '0);
			end
			ST_MUL_B: begin
				acc_q <= prod_s1;
			end
			ST_MUL_C: begin
				den_q <= MAG_W'(prod_s1);
			end
			ST_COMBINE: begin
				neg_q <= sum[PROD_W];
				mag_q <= sum_abs[MAG_W-1:0];
				ga_q <= sum_abs[MAG_W-1:0];
				gb_q <= den_q;
				k_q <= '0;
			end
			ST_GCD_TWO: begin
				// Strip the common power of two; it is put back on the gcd at the end.
				if (!ga_q[0] && !gb_q[0]) begin
					ga_q <= ga_q >> 1;
					gb_q <= gb_q >> 1;
					k_q <= k_q + 1'b1;
				end
			end
			ST_GCD_LOOP: begin
				if (ga_q != '0) begin
					if (!ga_q[0]) begin
						ga_q <= ga_q >> 1;
					end else if (!gb_q[0]) begin
						gb_q <= gb_q >> 1;
					end else if (!gdiff[MAG_W]) begin
						ga_q <= gdiff[MAG_W-1:0];
					end else begin
						gb_q <= MAG_W'(-gdiff);
					end
				end
			end
			ST_NUM_WAIT: begin
				if (div_done) begin
					mag_q <= div_quotient;
				end
			end
			ST_DEN_WAIT: begin
				if (div_done) begin
					res_num_q <= RES_NUM_W'(signed_num);
					res_den_q <= RES_DEN_W'(div_quotient);
				end
			end
			default: begin
			end
		endcase
	end

	assign result.res_num = res_num_q;
	assign result.res_den = res_den_q;
	assign result.div_zero = div_zero_q;

endmodule

// File: tb/rasm_checker.sv
`timescale 1ns / 1ps
// Checker for the rational add/subtract/multiply/reduce unit.
// Watches both channels, predicts each reduced fraction and compares it field by field.
// Depends on rasm_pkg, rasm_in_if and rasm_out_if.
module rasm_checker import rasm_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	rasm_in_if   operands,
	rasm_out_if  result,
	output int   errors,
	output int   pending
);

	typedef struct packed {
		logic signed [RES_NUM_W-1:0] num;
		logic [RES_DEN_W-1:0]        den;
		logic                        div_zero;
	} fraction_t;

	fraction_t expected_q[$];

	function automatic fraction_t reduce_fraction(
		input logic [1:0]              op,
		input logic signed [WIDTH-1:0] ln,
		input logic [DEN_W-1:0]        ld,
		input logic signed [WIDTH-1:0] rn,
		input logic [DEN_W-1:0]        rd
	);
		fraction_t     r;
		longint        num;
		longint unsigned den, mag, a, b, t, q, dq;
		logic          neg;
		r.num = '0;
		r.den = RES_DEN_W'(1);
		r.div_zero = 1'b0;
		if (ld == '0 || rd == '0) begin
			r.div_zero = 1'b1;
			return r;
		end
		// The unused code shares the multiply path, since the unit treats every code but add and subtract as multiply.
		if (op == OP_ADD)
			num = longint'(ln) * longint'(rd) + longint'(ld) * longint'(rn);
		else if (op == OP_SUB)
			num = longint'(ln) * longint'(rd) - longint'(ld) * longint'(rn);
		else
			num = longint'(ln) * longint'(rn);
		den = longint'(ld) * longint'(rd);
		if (num == 0)
			return r;
		neg = num < 0;
		mag = neg ? -num : num;
		a = mag;
		b = den;
		while (a != 0) begin
			t = b % a;
			b = a;
			a = t;
		end
		q = mag / b;
		dq = den / b;
		r.num = neg ? -q[RES_NUM_W-1:0] : q[RES_NUM_W-1:0];
		r.den = dq[RES_DEN_W-1:0];
		return r;
	endfunction

	// Both counts start at zero, as every int does.
	always @(posedge clk) begin
		fraction_t want;
		if (arst_n) begin
			if (operands.valid && operands.ready)
				expected_q.push_back(reduce_fraction(operands.op, operands.lhs_num,
					operands.lhs_den, operands.rhs_num, operands.rhs_den));
			if (result.valid && result.ready) begin
				if (expected_q.size() == 0) begin
					$error("result %0d/%0d arrived with no request outstanding",
						result.res_num, result.res_den);
					errors++;
				end else begin
					want = expected_q.pop_front();
					if (result.res_num !== want.num) begin
						$error("res_num: expected %0d, got %0d", want.num, result.res_num);
						errors++;
					end
					if (result.res_den !== want.den) begin
						$error("res_den: expected %0d, got %0d", want.den, result.res_den);
						errors++;
					end
					if (result.div_zero !== want.div_zero) begin
						$error("div_zero: expected %0d, got %0d", want.div_zero,
							result.div_zero);
						errors++;
					end
				end
			end
		end
		pending <= expected_q.size();
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the testbench for the rational add/subtract/multiply/reduce unit.
// Drives requests and result back-pressure, and gives the verdict from rasm_checker.
// Depends on rasm_pkg, rasm_in_if, rasm_out_if, rasm_checker and the unit itself.
module tb_top;
	import rasm_pkg::*;

	localparam logic [1:0] OP_RSVD = 2'd3;
	localparam logic signed [WIDTH-1:0] NUM_MAX = WIDTH'((1 << (WIDTH - 1)) - 1);
	localparam logic signed [WIDTH-1:0] NUM_MIN = WIDTH'(-(1 << (WIDTH - 1)));
	localparam logic [DEN_W-1:0] DEN_MAX = DEN_W'((1 << DEN_W) - 1);
	localparam int RANDOM_REQUESTS = 600;
	localparam int MAX_GAP = 18;
	localparam int HOLD_AT = 120;
	localparam int HOLD_CYCLES = 400;
	localparam int PAUSE_AT = 300;
	localparam int DRAIN_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n;
	int   errors;
	int   pending;
	int   idle_cycles;

	rasm_in_if  operands();
	rasm_out_if result();

	rational_add_sub_mul_reduce_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (operands),
		.result   (result)
	);

	rasm_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (operands),
		.result   (result),
		.errors   (errors),
		.pending  (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Every fourth stretch of requests or results runs with no idling at all.
	function automatic int draw_gap(input int count, input int period);
		return ((count / period) % 4 == 3) ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	function automatic logic signed [WIDTH-1:0] draw_num();
		case ($urandom_range(0, 5))
			0: return WIDTH'(int'($urandom_range(0, 40)) - 20);
			1: return $urandom_range(0, 1) ? WIDTH'(NUM_MAX) : WIDTH'(NUM_MIN);
			default: return WIDTH'($urandom);
		endcase
	endfunction

	function automatic logic [DEN_W-1:0] draw_den();
		case ($urandom_range(0, 15))
			0: return '0;
			1, 2, 3, 4: return DEN_W'($urandom_range(1, 24));
			5: return DEN_W'(DEN_MAX);
			default: return DEN_W'($urandom_range(1, DEN_MAX));
		endcase
	endfunction

	task automatic send_request(
		input int                      gap,
		input logic [1:0]              op,
		input logic signed [WIDTH-1:0] ln,
		input logic [DEN_W-1:0]        ld,
		input logic signed [WIDTH-1:0] rn,
		input logic [DEN_W-1:0]        rd
	);
		if (gap > 0) begin
			operands.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operands.op <= op;
		operands.lhs_num <= ln;
		operands.lhs_den <= ld;
		operands.rhs_num <= rn;
		operands.rhs_den <= rd;
		operands.valid <= 1'b1;
		do @(posedge clk); while (!operands.ready);
	endtask

	// The extra edge lets the checker's count include a request accepted at this edge.
	task automatic wait_for_drain();
		operands.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int n;
		arst_n <= 1'b0;
		operands.valid <= 1'b0;
		operands.op <= OP_ADD;
		operands.lhs_num <= '0;
		operands.lhs_den <= '0;
		operands.rhs_num <= '0;
		operands.rhs_den <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		send_request(draw_gap(0, 50), OP_ADD, 1, 2, 1, 3);
		send_request(draw_gap(0, 50), OP_SUB, 1, 2, 1, 2);
		send_request(draw_gap(0, 50), OP_SUB, 1, 4, 3, 4);
		send_request(draw_gap(0, 50), OP_ADD, -3, 4, 1, 4);
		send_request(draw_gap(0, 50), OP_ADD, -1, 1, 0, 1);
		send_request(draw_gap(0, 50), OP_MUL, NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX);
		send_request(draw_gap(0, 50), OP_MUL, NUM_MAX, DEN_MAX, NUM_MIN, 1);
		send_request(draw_gap(0, 50), OP_ADD, NUM_MIN, 1, NUM_MIN, 1);
		send_request(draw_gap(0, 50), OP_SUB, NUM_MAX, 1, NUM_MIN, 1);
		send_request(draw_gap(0, 50), OP_ADD, NUM_MAX, DEN_MAX, NUM_MAX, DEN_MAX);
		send_request(draw_gap(0, 50), OP_MUL, -1, DEN_MAX, 1, DEN_MAX);
		send_request(draw_gap(0, 50), OP_ADD, 1, DEN_MAX, 1, DEN_MAX - 1);
		send_request(draw_gap(0, 50), OP_SUB, NUM_MIN, DEN_MAX - 2, NUM_MAX, DEN_MAX);
		send_request(draw_gap(0, 50), OP_MUL, 0, 5, 7, 3);
		send_request(draw_gap(0, 50), OP_ADD, 5, 0, 1, 2);
		send_request(draw_gap(0, 50), OP_SUB, 1, 2, 5, 0);
		send_request(draw_gap(0, 50), OP_MUL, 3, 0, 4, 0);
		send_request(draw_gap(0, 50), OP_RSVD, 6, 4, -10, 9);
		send_request(draw_gap(0, 50), OP_RSVD, NUM_MIN, DEN_MAX, -1, 2);
		send_request(draw_gap(0, 50), OP_RSVD, 1, 0, 1, 1);

		for (n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n == PAUSE_AT)
				wait_for_drain();
			send_request(draw_gap(n, 50), 2'($urandom_range(0, 3)), draw_num(), draw_den(),
				draw_num(), draw_den());
		end

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result side: random back-pressure, and one long hold-off that keeps a result waiting in the unit.
	initial begin
		int gap;
		int taken;
		taken = 0;
		result.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = (taken == HOLD_AT) ? HOLD_CYCLES : draw_gap(taken, 70);
			if (gap > 0) begin
				result.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
			taken++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			idle_cycles <= 0;
		else if ((operands.valid && operands.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

endmodule
